/* design/fdtdu_pkg.sv */
// ----------------------------------------------------------------------------
// FDTD field update package
// Shared types, codes and saturation helper for the 1-D field engine.
// ----------------------------------------------------------------------------
package fdtdu_pkg;

    localparam int DEF_CELLS = 64;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_STEP = 2'd1,
        KIND_READ = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    localparam logic CFG_INV_CELL_SIZE = 1'b0;
    localparam logic CFG_SOURCE_CELL   = 1'b1;

    typedef struct packed {
        logic [1:0]         kind;
        logic [5:0]         cell_index;
        logic signed [31:0] h_coefficient;
        logic signed [31:0] e_coefficient;
        logic signed [31:0] source_value;
    } t_in_item;

    typedef struct packed {
        logic [5:0]         read_cell;
        logic signed [31:0] e_value;
        logic signed [31:0] h_value;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] e;
        logic signed [31:0] h;
        logic signed [31:0] hc;
        logic signed [31:0] ec;
    } t_cell;

    typedef struct packed {
        logic load_first;
        logic load_second;
    } t_upd_ctrl;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -65'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* design/fdtd_1d_field_update_unit.sv */
// ----------------------------------------------------------------------------
// FDTD 1-D field update unit
// Top level: a rotating chain of cells with one shared update unit at its head.
// ----------------------------------------------------------------------------
// The cells form a ring that rotates by one place whenever the head cell has
// been handled. A step transaction makes one H sweep and then one E sweep round
// the ring; at each cell the two-multiplier update unit registers its first
// product, then its second, and the result is written back as the ring rotates.
// A load or read transaction makes one full rotation that brings the addressed
// cell to the head. After either, the block returns to idle, where the next
// transaction is taken. A read result is held in an output register, so further
// transactions are taken while it waits; a later read holds its last rotation
// cycle until that register is free.
module fdtd_1d_field_update_unit #(
    parameter int CELLS = fdtdu_pkg::DEF_CELLS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  fdtdu_pkg::t_in_item  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output fdtdu_pkg::t_out_item o_data,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [30:0]          i_cfg_data
);
    import fdtdu_pkg::*;

    localparam int CW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [CW-1:0] LAST = CW'(CELLS - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_HPASS = 4'b0010,
        ST_EPASS = 4'b0100,
        ST_SWEEP = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [1:0] r_phase, n_phase;
    logic [30:0] r_inv;
    logic [5:0] r_src_cell;
    t_in_item r_item;
    logic signed [31:0] r_hd1, r_hd2, r_ed1, r_ed2;
    logic r_out_valid;
    t_out_item r_out;
    t_out_item r_rd, rd_now;
    logic rd_hold, rd_done;

    t_cell cells [CELLS];
    t_cell cell_next [CELLS];
    t_cell head_new;
    logic shift;
    logic accept, last_cell, match, add_src;
    t_upd_ctrl upd_ctrl;
    logic signed [31:0] op_f, op_c, op_a, op_b, upd_res;

    genvar g;
    generate
        for (g = 0; g < CELLS; g++) begin : g_cell
            if (g < CELLS - 1) begin : g_mid
                assign cell_next[g] = cells[g+1];
            end else begin : g_end
                assign cell_next[g] = head_new;
            end
            fdtdu_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_next  (cell_next[g]),
                .o_state (cells[g])
            );
        end
    endgenerate

    assign accept    = i_valid && !o_stall;
    assign o_stall   = (r_state != ST_IDLE);
    assign last_cell = (r_cnt == LAST);
    assign match     = (int'(r_cnt) == int'(r_item.cell_index));
    assign add_src   = (r_state == ST_EPASS) && (int'(r_cnt) == int'(r_src_cell));
    assign rd_hold   = r_out_valid && i_stall && last_cell && (r_item.kind == KIND_READ);
    assign rd_done   = (r_state == ST_SWEEP) && last_cell && (r_item.kind == KIND_READ)
                       && !rd_hold;

    always_comb begin
        rd_now = r_rd;
        if (match) begin
            rd_now.e_value = cells[0].e;
            rd_now.h_value = cells[0].h;
        end
    end

    always_comb begin
        if (r_state == ST_HPASS) begin
            op_f = cells[0].h;
            op_c = cells[0].hc;
            op_a = last_cell ? r_ed2 : cells[1 % CELLS].e;
            op_b = cells[0].e;
        end else begin
            op_f = cells[0].e;
            op_c = cells[0].ec;
            op_a = cells[0].h;
            op_b = (r_cnt == '0) ? r_hd2 : cells[CELLS-1].h;
        end
        upd_ctrl.load_first  = (r_phase == 2'd0);
        upd_ctrl.load_second = (r_phase == 2'd1);
    end

    fdtdu_update u_update (
        .i_clk     (i_clk),
        .i_ctrl    (upd_ctrl),
        .i_f       (op_f),
        .i_c       (op_c),
        .i_a       (op_a),
        .i_b       (op_b),
        .i_inv     (r_inv),
        .i_add_src (add_src),
        .i_src     (r_item.source_value),
        .o_result  (upd_res)
    );

    always_comb begin
        head_new = cells[0];
        shift    = 1'b0;
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_phase  = r_phase;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt   = '0;
                n_phase = 2'd0;
                if (accept) begin
                    unique case (i_data.kind) inside
                        KIND_STEP: n_state = ST_HPASS;
                        KIND_LOAD, KIND_READ: n_state = ST_SWEEP;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_HPASS, ST_EPASS: begin
                if (r_state == ST_HPASS) begin
                    head_new.h = upd_res;
                end else begin
                    head_new.e = upd_res;
                end
                if (r_phase == 2'd2) begin
                    shift   = 1'b1;
                    n_phase = 2'd0;
                    n_cnt   = r_cnt + 1'b1;
                    if (last_cell) begin
                        n_cnt   = '0;
                        n_state = (r_state == ST_HPASS) ? ST_EPASS : ST_IDLE;
                    end
                end else begin
                    n_phase = r_phase + 2'd1;
                end
            end
            ST_SWEEP: begin
                if (!rd_hold) begin
                    shift = 1'b1;
                    if (match && r_item.kind == KIND_LOAD) begin
                        head_new.hc = r_item.h_coefficient;
                        head_new.ec = r_item.e_coefficient;
                    end
                    n_cnt = r_cnt + 1'b1;
                    if (last_cell) begin
                        n_cnt   = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_phase     <= 2'd0;
            r_inv       <= 31'd16777216;
            r_src_cell  <= '0;
            r_hd1       <= '0;
            r_hd2       <= '0;
            r_ed1       <= '0;
            r_ed2       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_phase <= n_phase;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_INV_CELL_SIZE: r_inv      <= i_cfg_data;
                    CFG_SOURCE_CELL:   r_src_cell <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (r_state == ST_HPASS && r_cnt == '0 && r_phase == 2'd0) begin
                r_hd2 <= r_hd1;
                r_hd1 <= cells[0].h;
            end
            if (r_state == ST_EPASS && r_cnt == '0 && r_phase == 2'd2) begin
                r_ed2 <= r_ed1;
                r_ed1 <= cells[CELLS-1].e;
            end
            if (rd_done) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_data;
            r_rd   <= '{read_cell: i_data.cell_index, e_value: '0, h_value: '0};
        end else if (r_state == ST_SWEEP && r_item.kind == KIND_READ) begin
            r_rd <= rd_now;
        end
        if (rd_done) begin
            r_out <= rd_now;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* design/fdtdu_cell.sv */
// ----------------------------------------------------------------------------
// FDTD chain cell
// Holds the fields and coefficients of one cell and passes them on when the
// chain rotates.
// ----------------------------------------------------------------------------
module fdtdu_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  fdtdu_pkg::t_cell i_next,
    output fdtdu_pkg::t_cell o_state
);
    import fdtdu_pkg::*;

    logic signed [31:0] r_e, r_h, r_hc, r_ec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e <= '0;
            r_h <= '0;
        end else if (i_shift) begin
            r_e <= i_next.e;
            r_h <= i_next.h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_hc <= i_next.hc;
            r_ec <= i_next.ec;
        end
    end

    assign o_state = '{e: r_e, h: r_h, hc: r_hc, ec: r_ec};

endmodule

/* design/fdtdu_update.sv */
// ----------------------------------------------------------------------------
// FDTD update unit
// Computes f + c * (a - b) * inv, registering both products, with an optional
// source addition, in Q8.24 with rounding and saturation.
// ----------------------------------------------------------------------------
module fdtdu_update (
    input  logic                 i_clk,
    input  fdtdu_pkg::t_upd_ctrl i_ctrl,
    input  logic signed [31:0]   i_f,
    input  logic signed [31:0]   i_c,
    input  logic signed [31:0]   i_a,
    input  logic signed [31:0]   i_b,
    input  logic [30:0]          i_inv,
    input  logic                 i_add_src,
    input  logic signed [31:0]   i_src,
    output logic signed [31:0]   o_result
);
    import fdtdu_pkg::*;

    logic signed [64:0] r_prod1;
    logic signed [64:0] r_prod2;
    logic signed [32:0] diff;
    logic signed [64:0] n_prod1, n_prod2, rnd1, rnd2, sum, sum2;
    logic signed [31:0] scaled, upd;

    always_comb begin
        diff    = 33'(i_a) - 33'(i_b);
        n_prod1 = 65'(diff) * 65'(signed'({1'b0, i_inv}));
        rnd1    = (r_prod1 + 65'sd8388608) >>> 24;
        scaled  = sat32(rnd1);
        n_prod2 = 65'(i_c) * 65'(scaled);
        rnd2    = (r_prod2 + 65'sd8388608) >>> 24;
        sum     = rnd2 + 65'(i_f);
        upd     = sat32(sum);
        sum2    = 65'(upd) + 65'(i_src);
        o_result = i_add_src ? sat32(sum2) : upd;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_first) begin
            r_prod1 <= n_prod1;
        end
        if (i_ctrl.load_second) begin
            r_prod2 <= n_prod2;
        end
    end

endmodule

/* verif/fdtd_1d_field_update_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FDTD 1-D field update unit testbench
// Drives load, step and read transactions with random idling on both sides,
// predicts the field arrays and delay boundary in Q8.24, and checks every read.
// ----------------------------------------------------------------------------
module fdtd_1d_field_update_unit_test;
    import fdtdu_pkg::*;

    localparam int NCELLS = 64;
    localparam int SETTLE_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        drv_valid = 1'b0;
    logic        o_stall;
    t_in_item    drv_item = '0;
    logic        o_valid;
    logic        rcv_stall = 1'b0;
    t_out_item   o_data;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_INV_CELL_SIZE;
    logic [30:0] cfg_data = '0;

    fdtd_1d_field_update_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (drv_valid),
        .o_stall    (o_stall),
        .i_data     (drv_item),
        .o_valid    (o_valid),
        .i_stall    (rcv_stall),
        .o_data     (o_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_in_item  pending_items[$];
    t_out_item expected_reads[$];
    int        error_count = 0;
    int        gap_left = 0;
    int        stall_left = 0;
    int        quiet_cycles = 0;
    bit        no_send_idle = 1'b0;
    bit        no_recv_stall = 1'b0;

    logic [30:0]        inv_size_q = 31'd16777216;
    logic [5:0]         src_cell_q = 6'd0;
    logic signed [31:0] e_arr[NCELLS];
    logic signed [31:0] h_arr[NCELLS];
    logic signed [31:0] hc_arr[NCELLS];
    logic signed [31:0] ec_arr[NCELLS];
    logic signed [31:0] h0_old1, h0_old2, elast_old1, elast_old2;

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] field_update(input logic signed [31:0] f,
            input logic signed [31:0] c, input logic signed [31:0] a,
            input logic signed [31:0] b);
        longint d;
        longint scaled;
        longint prod;
        logic signed [31:0] s;
        d = longint'(a) - longint'(b);
        scaled = d * longint'({33'd0, inv_size_q});
        s = clip32((scaled + 64'sd8388608) >>> 24);
        prod = (longint'(c) * longint'(s) + 64'sd8388608) >>> 24;
        return clip32(longint'(f) + prod);
    endfunction

    task automatic advance_fields(input logic signed [31:0] src);
        h0_old2 = h0_old1;
        h0_old1 = h_arr[0];
        for (int j = 0; j < NCELLS - 1; j++) begin
            h_arr[j] = field_update(h_arr[j], hc_arr[j], e_arr[j + 1], e_arr[j]);
        end
        h_arr[NCELLS - 1] = field_update(h_arr[NCELLS - 1], hc_arr[NCELLS - 1],
                                         elast_old2, e_arr[NCELLS - 1]);
        e_arr[0] = field_update(e_arr[0], ec_arr[0], h_arr[0], h0_old2);
        elast_old2 = elast_old1;
        elast_old1 = e_arr[NCELLS - 1];
        for (int j = 1; j < NCELLS; j++) begin
            e_arr[j] = field_update(e_arr[j], ec_arr[j], h_arr[j], h_arr[j - 1]);
        end
        if (src_cell_q < NCELLS) begin
            e_arr[src_cell_q] = clip32(longint'(e_arr[src_cell_q]) + longint'(src));
        end
    endtask

    task automatic predict_item(input t_in_item it);
        t_out_item r;
        case (it.kind)
            KIND_LOAD: begin
                hc_arr[it.cell_index] = it.h_coefficient;
                ec_arr[it.cell_index] = it.e_coefficient;
            end
            KIND_STEP: begin
                advance_fields(it.source_value);
            end
            KIND_READ: begin
                r.read_cell = it.cell_index;
                r.e_value = e_arr[it.cell_index];
                r.h_value = h_arr[it.cell_index];
                expected_reads.push_back(r);
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        logic next_valid;
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
            gap_left = 0;
        end else begin
            next_valid = drv_valid;
            if (drv_valid && !o_stall) begin
                predict_item(drv_item);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0) begin
                    drv_item <= pending_items.pop_front();
                    next_valid = 1'b1;
                    gap_left = no_send_idle ? 0 : $urandom_range(0, 6);
                end
            end
            drv_valid <= next_valid;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !rcv_stall) begin
            if (expected_reads.size() == 0) begin
                $error("unexpected read result for cell %0d", o_data.read_cell);
                error_count++;
            end else begin
                want = expected_reads.pop_front();
                if (o_data.read_cell !== want.read_cell) begin
                    $error("read_cell: expected %0d, actual %0d",
                           want.read_cell, o_data.read_cell);
                    error_count++;
                end
                if (o_data.e_value !== want.e_value) begin
                    $error("e_value: expected %0d, actual %0d", want.e_value, o_data.e_value);
                    error_count++;
                end
                if (o_data.h_value !== want.h_value) begin
                    $error("h_value: expected %0d, actual %0d", want.h_value, o_data.h_value);
                    error_count++;
                end
            end
            stall_left = no_recv_stall ? 0 : $urandom_range(0, 6);
        end
        if (stall_left > 0) begin
            rcv_stall <= 1'b1;
            stall_left--;
        end else begin
            rcv_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((drv_valid && !o_stall) || (o_valid && !rcv_stall) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("fdtd_1d_field_update_unit: mismatch");
                $finish;
            end
        end
    end

    function automatic logic signed [31:0] random_q24();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) it.kind = KIND_LOAD;
        else if (pick < 45) it.kind = KIND_STEP;
        else if (pick < 95) it.kind = KIND_READ;
        else it.kind = KIND_NONE;
        it.cell_index = 6'($urandom_range(0, NCELLS - 1));
        it.h_coefficient = random_q24();
        it.e_coefficient = random_q24();
        it.source_value = random_q24();
        return it;
    endfunction

    task automatic queue_item(input t_kind k, input logic [5:0] cell_id,
            input logic signed [31:0] hc, input logic signed [31:0] ec,
            input logic signed [31:0] src);
        t_in_item it;
        it.kind = k;
        it.cell_index = cell_id;
        it.h_coefficient = hc;
        it.e_coefficient = ec;
        it.source_value = src;
        pending_items.push_back(it);
    endtask

    task automatic write_register(input logic idx, input logic [30:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == CFG_INV_CELL_SIZE) inv_size_q = value;
        else src_cell_q = value[5:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_and_settle();
        @(posedge i_clk);
        while (pending_items.size() > 0 || drv_valid || expected_reads.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < NCELLS; i++) begin
            e_arr[i] = '0;
            h_arr[i] = '0;
            hc_arr[i] = '0;
            ec_arr[i] = '0;
        end
        h0_old1 = '0;
        h0_old2 = '0;
        elast_old1 = '0;
        elast_old2 = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_item(KIND_READ, 6'd0, '0, '0, '0);
        queue_item(KIND_READ, 6'd63, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        queue_item(KIND_NONE, 6'd63, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        for (int i = 0; i < NCELLS; i++) begin
            queue_item(KIND_LOAD, i[5:0], 32'sh0080_0000, 32'sh0040_0000, '0);
        end
        queue_item(KIND_STEP, 6'd0, '0, '0, 32'sh7fffffff);
        queue_item(KIND_READ, 6'd0, '0, '0, '0);
        queue_item(KIND_READ, 6'd1, '0, '0, '0);
        queue_item(KIND_STEP, 6'd0, '0, '0, 32'sh80000000);
        queue_item(KIND_STEP, 6'd0, '0, '0, 32'sh7fffffff);
        queue_item(KIND_READ, 6'd0, '0, '0, '0);
        queue_item(KIND_LOAD, 6'd63, 32'sh7fffffff, 32'sh80000000, '0);
        queue_item(KIND_LOAD, 6'd0, 32'sh80000000, 32'sh7fffffff, '0);
        queue_item(KIND_STEP, 6'd0, '0, '0, 32'sh0100_0000);
        queue_item(KIND_STEP, 6'd0, '0, '0, '0);
        queue_item(KIND_READ, 6'd63, '0, '0, '0);
        queue_item(KIND_READ, 6'd62, '0, '0, '0);
        queue_item(KIND_READ, 6'd0, '0, '0, '0);
        drain_and_settle();

        for (int p = 0; p < 6; p++) begin
            case (p)
                1: write_register(CFG_INV_CELL_SIZE, 31'h7fffffff);
                2: write_register(CFG_INV_CELL_SIZE, 31'd0);
                3: begin
                    write_register(CFG_INV_CELL_SIZE, 31'h0080_0000);
                    write_register(CFG_SOURCE_CELL, 31'd63);
                end
                4: write_register(CFG_SOURCE_CELL, 31'($urandom_range(0, 63)));
                5: begin
                    write_register(CFG_INV_CELL_SIZE, 31'($urandom));
                    write_register(CFG_SOURCE_CELL, 31'd0);
                end
                default: begin
                end
            endcase
            no_send_idle = (p == 2);
            no_recv_stall = (p == 2) || (p == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pending_items.push_back(random_item());
            end
            drain_and_settle();
        end

        if (error_count == 0) begin
            $display("fdtd_1d_field_update_unit: match");
        end else begin
            $display("fdtd_1d_field_update_unit: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
design/fdtdu_pkg.sv
design/fdtdu_cell.sv
design/fdtdu_update.sv
design/fdtd_1d_field_update_unit.sv
verif/fdtd_1d_field_update_unit_test.sv
